[design/stl_pkg.sv]
// Package for the script token lexer: token kinds, the token and queue record types,
// character classes and the keyword table.
// Has no dependencies; every other file of the block imports it.
package stl_pkg;

  localparam logic [4:0] K_PLUS      = 5'd0;
  localparam logic [4:0] K_BMINUS    = 5'd1;
  localparam logic [4:0] K_UMINUS    = 5'd2;
  localparam logic [4:0] K_MUL       = 5'd3;
  localparam logic [4:0] K_DIV       = 5'd4;
  localparam logic [4:0] K_LPAREN    = 5'd5;
  localparam logic [4:0] K_RPAREN    = 5'd6;
  localparam logic [4:0] K_SEMI      = 5'd7;
  localparam logic [4:0] K_ASSIGN    = 5'd8;
  localparam logic [4:0] K_BANG      = 5'd10;
  localparam logic [4:0] K_LESS      = 5'd12;
  localparam logic [4:0] K_GREATER   = 5'd14;
  localparam logic [4:0] K_NUMBER    = 5'd16;
  localparam logic [4:0] K_STRING    = 5'd17;
  localparam logic [4:0] K_IDENT     = 5'd18;
  localparam logic [4:0] K_TRUE      = 5'd19;
  localparam logic [4:0] K_NIL       = 5'd21;
  localparam logic [4:0] K_UNKNOWN   = 5'd26;
  localparam logic [4:0] K_UNTERM    = 5'd27;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  localparam logic [15:0] LEN_MAX = 16'hFFFF;
  localparam int KW_COUNT = 7;

  // Keywords packed with the first character in the lowest byte.
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    64'h0000_0000_6575_7274, 64'h0000_0065_736C_6166, 64'h0000_0000_006C_696E,
    64'h0000_0074_6E69_7270, 64'h0000_0000_0072_6176, 64'h0000_0000_0064_6E61,
    64'h0000_0000_0000_726F
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd4, 4'd5, 4'd3, 4'd5, 4'd3, 4'd3, 4'd2};
  localparam logic [4:0] KW_KIND [KW_COUNT] = '{5'd19, 5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25};

  typedef struct packed {
    logic [15:0] length;
    logic [23:0] start;
    logic [15:0] line;
    logic [4:0]  kind;
  } token_t;

  typedef struct packed {
    logic   two;
    token_t second;
    token_t first;
  } rec_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

endpackage

[design/stl_front.sv]
// Front end of the script token lexer: accepts source bytes, runs the scan state
// and forms up to two tokens per byte as one queue record. Depends on stl_pkg.
module stl_front #(
  parameter int OFFSET_BITS   = 24,
  parameter int LINE_BITS     = 16,
  parameter int KEYWORD_CHARS = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic          in_eos,
  input  logic          full,
  output logic          push,
  output stl_pkg::rec_t push_rec
);
  import stl_pkg::*;

  localparam int PW = 8 * KEYWORD_CHARS;
  localparam logic [OFFSET_BITS-1:0] OFF_MAX  = {OFFSET_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};

  typedef enum logic [3:0] {
    M_IDLE, M_EQ, M_BANG, M_LT, M_GT, M_SLASH, M_COMMENT, M_STRING, M_INT, M_FRAC, M_WORD
  } mode_t;

  mode_t                  mode, mode_next;
  logic [PW-1:0]          prefix, prefix_next;
  logic [OFFSET_BITS-1:0] tok_start, tok_start_next;
  logic [15:0]            tok_len, tok_len_next;
  logic [OFFSET_BITS-1:0] pos, pos_next;
  logic [LINE_BITS-1:0]   line, line_next;
  logic [4:0]             prev_kind, prev_kind_next;
  logic                   have_prev, have_prev_next;

  mode_t                  m1, m2;
  logic [PW-1:0]          prefix1;
  logic [15:0]            tlen1;
  logic [LINE_BITS-1:0]   line1;
  logic                   handled, emit_a, emit_b, emit_c, accept, minus_bin, hp;
  logic [4:0]             kind_a, kind_b, kind_c, pk;
  logic [15:0]            len_a;
  token_t                 tok_a, tok_b, tok_c;

  function automatic logic [4:0] single_kind(input mode_t m);
    case (m)
      M_EQ:    return K_ASSIGN;
      M_BANG:  return K_BANG;
      M_LT:    return K_LESS;
      M_GT:    return K_GREATER;
      default: return K_DIV;
    endcase
  endfunction

  function automatic logic [4:0] word_kind(input logic [PW-1:0] p, input logic [15:0] n);
    logic [4:0] k;
    k = K_IDENT;
    if (n <= 16'(KEYWORD_CHARS)) begin
      for (int i = 0; i < KW_COUNT; i++) begin
        if ((n == 16'(KW_LEN[i])) && (64'(p) == KW_TEXT[i])) k = KW_KIND[i];
      end
    end
    return k;
  endfunction

  function automatic logic [PW-1:0] add_char(input logic [PW-1:0] p, input logic [15:0] n,
                                             input logic [7:0] c);
    logic [PW-1:0] r;
    r = p;
    for (int i = 0; i < KEYWORD_CHARS; i++) begin
      if (n == 16'(i)) r[8*i +: 8] = c;
    end
    return r;
  endfunction

  function automatic logic [15:0] len_inc(input logic [15:0] n);
    return (n != LEN_MAX) ? n + 16'd1 : n;
  endfunction

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    handled = 1'b0;
    emit_a  = 1'b0;
    kind_a  = K_PLUS;
    len_a   = 16'd1;
    m1      = mode;
    prefix1 = prefix;
    tlen1   = tok_len;
    line1   = line;
    case (mode)
      M_EQ, M_BANG, M_LT, M_GT: begin
        emit_a = 1'b1;
        m1     = M_IDLE;
        if (in_byte == "=") begin
          kind_a  = single_kind(mode) + 5'd1;
          len_a   = 16'd2;
          handled = 1'b1;
        end else begin
          kind_a = single_kind(mode);
        end
      end
      M_SLASH: begin
        if (in_byte == "/") begin
          m1      = M_COMMENT;
          handled = 1'b1;
        end else begin
          emit_a = 1'b1;
          kind_a = K_DIV;
          m1     = M_IDLE;
        end
      end
      M_COMMENT: begin
        if (in_byte == CH_LF) m1 = M_IDLE;
        else handled = 1'b1;
      end
      M_STRING: begin
        handled = 1'b1;
        if (in_byte == CH_QUOTE) begin
          emit_a = 1'b1;
          kind_a = K_STRING;
          len_a  = tok_len;
          m1     = M_IDLE;
        end else begin
          if (in_byte == CH_LF && line != LINE_MAX) line1 = line + LINE_BITS'(1);
          tlen1 = len_inc(tok_len);
        end
      end
      M_INT, M_FRAC: begin
        if (is_digit(in_byte) || (in_byte == "." && mode == M_INT)) begin
          if (in_byte == ".") m1 = M_FRAC;
          tlen1   = len_inc(tok_len);
          handled = 1'b1;
        end else begin
          emit_a = 1'b1;
          kind_a = K_NUMBER;
          len_a  = tok_len;
          m1     = M_IDLE;
        end
      end
      M_WORD: begin
        if (is_alpha(in_byte) || is_digit(in_byte)) begin
          prefix1 = add_char(prefix, tok_len, in_byte);
          tlen1   = len_inc(tok_len);
          handled = 1'b1;
        end else begin
          emit_a = 1'b1;
          kind_a = word_kind(prefix, tok_len);
          len_a  = tok_len;
          m1     = M_IDLE;
        end
      end
      default: m1 = M_IDLE;
    endcase

    pk        = emit_a ? kind_a : prev_kind;
    hp        = emit_a || have_prev;
    minus_bin = hp && (pk == K_RPAREN || pk == K_NUMBER || pk == K_STRING ||
                       (pk >= K_TRUE && pk <= K_NIL));

    m2             = m1;
    tok_start_next = tok_start;
    tok_len_next   = tlen1;
    prefix_next    = prefix1;
    line_next      = line1;
    emit_b         = 1'b0;
    kind_b         = K_UNKNOWN;
    if (!handled) begin
      case (in_byte)
        "+": begin emit_b = 1'b1; kind_b = K_PLUS; end
        "*": begin emit_b = 1'b1; kind_b = K_MUL; end
        "(": begin emit_b = 1'b1; kind_b = K_LPAREN; end
        ")": begin emit_b = 1'b1; kind_b = K_RPAREN; end
        ";": begin emit_b = 1'b1; kind_b = K_SEMI; end
        "-": begin emit_b = 1'b1; kind_b = minus_bin ? K_BMINUS : K_UMINUS; end
        "=", "!", "<", ">", "/": begin
          m2 = (in_byte == "=") ? M_EQ : (in_byte == "!") ? M_BANG :
               (in_byte == "<") ? M_LT : (in_byte == ">") ? M_GT : M_SLASH;
          tok_start_next = pos;
          tok_len_next   = 16'd0;
          prefix_next    = '0;
        end
        CH_LF: if (line1 != LINE_MAX) line_next = line1 + LINE_BITS'(1);
        " ", CH_TAB, CH_CR: ;
        CH_QUOTE: begin
          m2             = M_STRING;
          tok_start_next = (pos != OFF_MAX) ? pos + OFFSET_BITS'(1) : pos;
          tok_len_next   = 16'd0;
          prefix_next    = '0;
        end
        default: begin
          if (is_digit(in_byte) || is_alpha(in_byte)) begin
            m2             = is_digit(in_byte) ? M_INT : M_WORD;
            tok_start_next = pos;
            tok_len_next   = 16'd1;
            prefix_next    = PW'(in_byte);
          end else begin
            emit_b = 1'b1;
            kind_b = K_UNKNOWN;
          end
        end
      endcase
    end

    emit_c = 1'b0;
    kind_c = K_NUMBER;
    if (in_eos) begin
      case (m2)
        M_EQ, M_BANG, M_LT, M_GT, M_SLASH: begin emit_c = 1'b1; kind_c = single_kind(m2); end
        M_STRING: begin emit_c = 1'b1; kind_c = K_UNTERM; end
        M_INT, M_FRAC: begin emit_c = 1'b1; kind_c = K_NUMBER; end
        M_WORD: begin emit_c = 1'b1; kind_c = word_kind(prefix_next, tok_len_next); end
        default: emit_c = 1'b0;
      endcase
    end

    tok_a = '{length: len_a, start: 24'(tok_start), line: 16'(line), kind: kind_a};
    tok_b = '{length: 16'd1, start: 24'(pos), line: 16'(line_next), kind: kind_b};
    tok_c = '{length: (m2 == M_EQ || m2 == M_BANG || m2 == M_LT || m2 == M_GT ||
                       m2 == M_SLASH) ? 16'd1 : tok_len_next,
              start: 24'(tok_start_next), line: 16'(line_next), kind: kind_c};

    push_rec.first  = emit_a ? tok_a : (emit_b ? tok_b : tok_c);
    push_rec.second = emit_b ? tok_b : tok_c;
    push_rec.two    = emit_a && (emit_b || emit_c);
    push            = accept && (emit_a || emit_b || emit_c);

    prev_kind_next = emit_c ? kind_c : (emit_b ? kind_b : (emit_a ? kind_a : prev_kind));
    if (in_eos) begin
      mode_next      = M_IDLE;
      pos_next       = '0;
      line_next      = LINE_BITS'(1);
      have_prev_next = 1'b0;
    end else begin
      mode_next      = m2;
      pos_next       = (pos != OFF_MAX) ? pos + OFFSET_BITS'(1) : pos;
      have_prev_next = have_prev || emit_a || emit_b || emit_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_IDLE;
      prefix    <= '0;
      tok_start <= '0;
      tok_len   <= '0;
      pos       <= '0;
      line      <= LINE_BITS'(1);
      prev_kind <= K_PLUS;
      have_prev <= 1'b0;
    end else if (accept) begin
      mode      <= mode_next;
      prefix    <= prefix_next;
      tok_start <= tok_start_next;
      tok_len   <= tok_len_next;
      pos       <= pos_next;
      line      <= line_next;
      prev_kind <= prev_kind_next;
      have_prev <= have_prev_next;
    end
  end

endmodule

[design/stl_fifo.sv]
// Short record queue between the lexer front end and the token output stage.
// Depends on stl_pkg for the record type.
module stl_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  stl_pkg::rec_t push_rec,
  output logic          full,
  input  logic          pop,
  output stl_pkg::rec_t head,
  output logic          empty
);
  import stl_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rec_t             store [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) store[wr_ptr] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop) count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

endmodule

[design/stl_back.sv]
// Token output stage: takes records from the queue and presents their tokens one
// transfer at a time through an output register. Depends on stl_pkg.
module stl_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          empty,
  input  stl_pkg::rec_t head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [63:0]   out_data,
  output logic          out_last
);
  import stl_pkg::*;

  token_t out_tok;
  logic   sel, load;

  assign load     = !out_valid || out_ready;
  assign pop      = load && !empty && (sel || !head.two);
  assign out_data = {3'b000, out_tok};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
    end else if (load) begin
      out_valid <= !empty;
      if (!empty) sel <= !sel && head.two;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      out_tok  <= sel ? head.second : head.first;
      out_last <= sel || !head.two;
    end
  end

endmodule

[design/script_token_lexer_unit.sv]
// Script token lexer top level. A completed token passes through the record queue and
// the output register before it is presented. Throughput is one byte per cycle while
// the queue is not full; a byte that finishes two tokens needs two output transfers,
// and a four-record queue between front end and output stage absorbs that.
// Synchronous reset returns the scan state and counters to the start of a text and
// empties the queue and the output register. Depends on stl_pkg and the stl_* modules.
module script_token_lexer_unit #(
  parameter int OFFSET_BITS   = 24,
  parameter int LINE_BITS     = 16,
  parameter int KEYWORD_CHARS = 5,
  parameter int FIFO_DEPTH    = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // char_byte[7:0]
  input  logic        s_axis_tlast,  // end_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // token_kind[4:0], line_number[20:5],
                                     // start_offset[44:21], lexeme_length[60:45], zeros
  output logic        m_axis_tlast   // last_of_run
);
  import stl_pkg::*;

  rec_t push_rec, head;
  logic push, full, pop, empty;

  stl_front #(
    .OFFSET_BITS  (OFFSET_BITS),
    .LINE_BITS    (LINE_BITS),
    .KEYWORD_CHARS(KEYWORD_CHARS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .in_byte (s_axis_tdata),
    .in_eos  (s_axis_tlast),
    .full    (full),
    .push    (push),
    .push_rec(push_rec)
  );

  stl_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_rec(push_rec),
    .full    (full),
    .pop     (pop),
    .head    (head),
    .empty   (empty)
  );

  stl_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .head     (head),
    .pop      (pop),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (m_axis_tdata),
    .out_last (m_axis_tlast)
  );

endmodule

[design/stl_checker.sv]
// Port-level checks for the script token lexer, attached to the top level by bind.
// Depends on stl_pkg for token kind codes.
module stl_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  import stl_pkg::*;

  logic [4:0]  kind;
  logic [15:0] length;

  assign kind   = m_axis_tdata[4:0];
  assign length = m_axis_tdata[60:45];

  // A waiting source byte keeps its contents until the transfer happens.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast))
    else $error("source byte changed while waiting");

  // A stalled token transfer keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("token changed while stalled");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> kind <= K_UNTERM && m_axis_tdata[63:61] == 3'b000)
    else $error("token kind out of range");

  // Operators are one or two bytes long.
  a_op_len: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && kind < K_NUMBER |-> length == 16'd1 || length == 16'd2)
    else $error("operator length wrong");

  // Only strings can be empty.
  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && kind != K_STRING && kind != K_UNTERM |-> length != 16'd0)
    else $error("empty lexeme");

endmodule

bind script_token_lexer_unit stl_checker u_stl_checker (.*);

[tb/stl_token_checker.sv]
`timescale 1ns / 1ps
// Token checker for the script token lexer: mirrors the scan state for every accepted
// source byte, queues the tokens it predicts and compares each token transfer with them.
// Depends on stl_pkg for the token kinds, character codes and the keyword table.
module stl_token_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          errors,
  output int          outstanding,
  output int          tokens_checked
);
  import stl_pkg::*;

  localparam int          KEY_CHARS  = 5;
  localparam logic [23:0] OFFSET_TOP = 24'hFF_FFFF;
  localparam logic [15:0] LINE_TOP   = 16'hFFFF;

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_EQ, MODE_BANG, MODE_LT, MODE_GT, MODE_SLASH,
    MODE_COMMENT, MODE_STRING, MODE_INT, MODE_FRAC, MODE_WORD
  } scan_mode_e;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] line;
    logic [23:0] start;
    logic [15:0] length;
    logic        last;
  } lexeme_t;

  scan_mode_e  mode;
  logic [39:0] prefix;
  logic [23:0] tok_start;
  logic [15:0] tok_len;
  logic [23:0] byte_pos;
  logic [15:0] line_cnt;
  logic [4:0]  prev_kind;
  logic        have_prev;

  lexeme_t expected_tokens[$];
  lexeme_t run_tokens[2];
  int      run_len;
  int      err_cnt = 0;
  int      tokens_seen = 0;
  int      outstanding_q = 0;

  assign errors = err_cnt;
  assign outstanding = outstanding_q;
  assign tokens_checked = tokens_seen;

  function automatic logic num_char(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic letter_char(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic logic [4:0] op_kind(input scan_mode_e m);
    case (m)
      MODE_EQ:   return K_ASSIGN;
      MODE_BANG: return K_BANG;
      MODE_LT:   return K_LESS;
      MODE_GT:   return K_GREATER;
      default:   return K_DIV;
    endcase
  endfunction

  function automatic logic [4:0] keyword_kind();
    logic [4:0] kind;
    kind = K_IDENT;
    if (tok_len <= KEY_CHARS) begin
      for (int k = 0; k < KW_COUNT; k++) begin
        if ((KW_LEN[k] == tok_len) && (KW_TEXT[k] == {24'd0, prefix})) kind = KW_KIND[k];
      end
    end
    return kind;
  endfunction

  function automatic logic minus_binary();
    return have_prev && ((prev_kind == K_RPAREN) || (prev_kind == K_NUMBER) ||
                         (prev_kind == K_STRING) ||
                         ((prev_kind >= K_TRUE) && (prev_kind <= K_NIL)));
  endfunction

  task automatic reset_scan();
    mode = MODE_IDLE;
    prefix = '0;
    tok_start = '0;
    tok_len = '0;
    byte_pos = '0;
    line_cnt = 16'd1;
    prev_kind = '0;
    have_prev = 1'b0;
  endtask

  task automatic bump_line();
    if (line_cnt != LINE_TOP) line_cnt = line_cnt + 16'd1;
  endtask

  task automatic grow_word(input logic [7:0] c);
    if (tok_len < KEY_CHARS) prefix[tok_len * 8 +: 8] = c;
    if (tok_len != LEN_MAX) tok_len = tok_len + 16'd1;
  endtask

  task automatic open_token(input scan_mode_e m, input logic [23:0] start, input logic [7:0] c);
    mode = m;
    tok_start = start;
    tok_len = '0;
    prefix = '0;
    if ((m == MODE_INT) || (m == MODE_WORD)) grow_word(c);
  endtask

  task automatic emit_token(input logic [4:0] kind, input logic [23:0] start,
                            input logic [15:0] len);
    lexeme_t t;
    t.kind = kind;
    t.line = line_cnt;
    t.start = start;
    t.length = len;
    t.last = 1'b0;
    run_tokens[run_len] = t;
    run_len++;
    prev_kind = kind;
    have_prev = 1'b1;
  endtask

  task automatic lex_byte(input logic [7:0] c, input logic eos);
    logic [23:0] pos;
    logic        consumed;
    pos = byte_pos;
    consumed = 1'b0;
    run_len = 0;
    case (mode)
      MODE_EQ, MODE_BANG, MODE_LT, MODE_GT: begin
        if (c == "=") begin
          emit_token(op_kind(mode) + 5'd1, tok_start, 16'd2);
          consumed = 1'b1;
        end else begin
          emit_token(op_kind(mode), tok_start, 16'd1);
        end
        mode = MODE_IDLE;
      end
      MODE_SLASH: begin
        if (c == "/") begin
          mode = MODE_COMMENT;
          consumed = 1'b1;
        end else begin
          emit_token(K_DIV, tok_start, 16'd1);
          mode = MODE_IDLE;
        end
      end
      MODE_COMMENT: begin
        if (c == CH_LF) mode = MODE_IDLE;
        else consumed = 1'b1;
      end
      MODE_STRING: begin
        consumed = 1'b1;
        if (c == CH_QUOTE) begin
          emit_token(K_STRING, tok_start, tok_len);
          mode = MODE_IDLE;
        end else begin
          if (c == CH_LF) bump_line();
          if (tok_len != LEN_MAX) tok_len = tok_len + 16'd1;
        end
      end
      MODE_INT, MODE_FRAC: begin
        if (num_char(c) || ((c == ".") && (mode == MODE_INT))) begin
          if (c == ".") mode = MODE_FRAC;
          if (tok_len != LEN_MAX) tok_len = tok_len + 16'd1;
          consumed = 1'b1;
        end else begin
          emit_token(K_NUMBER, tok_start, tok_len);
          mode = MODE_IDLE;
        end
      end
      MODE_WORD: begin
        if (letter_char(c) || num_char(c)) begin
          grow_word(c);
          consumed = 1'b1;
        end else begin
          emit_token(keyword_kind(), tok_start, tok_len);
          mode = MODE_IDLE;
        end
      end
      default: mode = MODE_IDLE;
    endcase

    if (!consumed) begin
      case (c)
        "+": emit_token(K_PLUS, pos, 16'd1);
        "*": emit_token(K_MUL, pos, 16'd1);
        "(": emit_token(K_LPAREN, pos, 16'd1);
        ")": emit_token(K_RPAREN, pos, 16'd1);
        ";": emit_token(K_SEMI, pos, 16'd1);
        "=": open_token(MODE_EQ, pos, c);
        "!": open_token(MODE_BANG, pos, c);
        "<": open_token(MODE_LT, pos, c);
        ">": open_token(MODE_GT, pos, c);
        "/": open_token(MODE_SLASH, pos, c);
        CH_LF: bump_line();
        " ", CH_TAB, CH_CR: ;
        CH_QUOTE: open_token(MODE_STRING, (pos != OFFSET_TOP) ? pos + 24'd1 : pos, c);
        "-": emit_token(minus_binary() ? K_BMINUS : K_UMINUS, pos, 16'd1);
        default: begin
          if (num_char(c)) open_token(MODE_INT, pos, c);
          else if (letter_char(c)) open_token(MODE_WORD, pos, c);
          else emit_token(K_UNKNOWN, pos, 16'd1);
        end
      endcase
    end

    if (eos) begin
      case (mode)
        MODE_EQ, MODE_BANG, MODE_LT, MODE_GT, MODE_SLASH:
          emit_token(op_kind(mode), tok_start, 16'd1);
        MODE_STRING: emit_token(K_UNTERM, tok_start, tok_len);
        MODE_INT, MODE_FRAC: emit_token(K_NUMBER, tok_start, tok_len);
        MODE_WORD: emit_token(keyword_kind(), tok_start, tok_len);
        default: ;
      endcase
      mode = MODE_IDLE;
      byte_pos = '0;
      line_cnt = 16'd1;
      have_prev = 1'b0;
    end else if (byte_pos != OFFSET_TOP) begin
      byte_pos = byte_pos + 24'd1;
    end

    if (run_len > 0) run_tokens[run_len - 1].last = 1'b1;
    for (int i = 0; i < run_len; i++) expected_tokens.push_back(run_tokens[i]);
  endtask

  task automatic report_mismatch(input string msg);
    if (err_cnt < 40) $display("MISMATCH at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic check_token();
    lexeme_t want;
    lexeme_t got;
    got.kind = m_axis_tdata[4:0];
    got.line = m_axis_tdata[20:5];
    got.start = m_axis_tdata[44:21];
    got.length = m_axis_tdata[60:45];
    got.last = m_axis_tlast;
    tokens_seen++;
    if (expected_tokens.size() == 0) begin
      report_mismatch($sformatf("token %0d kind %0d at offset %0d was not expected",
                                tokens_seen, got.kind, got.start));
      return;
    end
    want = expected_tokens.pop_front();
    if (got.kind != want.kind)
      report_mismatch($sformatf("token %0d kind %0d, expected %0d",
                                tokens_seen, got.kind, want.kind));
    if (got.line != want.line)
      report_mismatch($sformatf("token %0d line %0d, expected %0d",
                                tokens_seen, got.line, want.line));
    if (got.start != want.start)
      report_mismatch($sformatf("token %0d start %0d, expected %0d",
                                tokens_seen, got.start, want.start));
    if (got.length != want.length)
      report_mismatch($sformatf("token %0d length %0d, expected %0d",
                                tokens_seen, got.length, want.length));
    if (got.last != want.last)
      report_mismatch($sformatf("token %0d tlast %0b, expected %0b",
                                tokens_seen, got.last, want.last));
    if (m_axis_tdata[63:61] != 3'd0)
      report_mismatch($sformatf("token %0d padding bits %0b are not zero",
                                tokens_seen, m_axis_tdata[63:61]));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_scan();
      expected_tokens.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) lex_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) check_token();
    end
    outstanding_q <= expected_tokens.size();
  end

endmodule

[tb/tb_script_token_lexer_unit.sv]
`timescale 1ns / 1ps
// Top of the script token lexer testbench: drives source texts into the block under
// random idle and stall patterns and reports the verdict of stl_token_checker.
// Depends on stl_pkg, stl_token_checker and script_token_lexer_unit.
module tb_script_token_lexer_unit;
  import stl_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASE_ITEMS  = 225;
  localparam int IDLE_PCT [4]  = '{0, 65, 0, 34};
  localparam int STALL_PCT [4] = '{0, 0, 65, 34};
  localparam logic [7:0] OP_BYTES [11] = '{"+", "-", "*", "/", "(", ")", ";", "=", "!", "<", ">"};
  localparam logic [7:0] WS_BYTES [4]  = '{" ", CH_TAB, CH_CR, CH_LF};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tlast;

  int errors;
  int outstanding;
  int tokens_checked;
  int idle_pct = 0;
  int stall_pct = 0;
  int cycle_cnt = 0;
  int bytes_sent = 0;
  int texts_sent = 0;

  logic [8:0] source_q[$];

  script_token_lexer_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  stl_token_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tlast   (s_axis_tlast),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tlast   (m_axis_tlast),
    .errors         (errors),
    .outstanding    (outstanding),
    .tokens_checked (tokens_checked)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic put_byte(input logic [7:0] b);
    source_q.push_back({1'b0, b});
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic close_text();
    source_q[source_q.size() - 1][8] = 1'b1;
  endtask

  function automatic logic [7:0] rand_letter();
    int r;
    logic [7:0] b;
    r = $urandom_range(0, 52);
    if (r < 26) b = "a" + r[7:0];
    else if (r < 52) b = "A" + r[7:0] - 8'd26;
    else b = "_";
    return b;
  endfunction

  function automatic logic [7:0] rand_digit();
    int r;
    r = $urandom_range(0, 9);
    return "0" + r[7:0];
  endfunction

  function automatic logic [7:0] rand_word_char();
    return ($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter();
  endfunction

  function automatic logic [7:0] rand_string_char();
    int r;
    logic [7:0] b;
    r = $urandom_range(32, 126);
    b = r[7:0];
    if ($urandom_range(0, 7) == 0) b = CH_LF;
    else if (b == CH_QUOTE) b = "'";
    return b;
  endfunction

  // Mostly well-formed lexemes with random content, plus some raw noise bytes.
  task automatic put_fragment();
    int pick;
    int k;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      if ($urandom_range(0, 1) == 1) begin
        k = $urandom_range(0, KW_COUNT - 1);
        for (int i = 0; i < KW_LEN[k]; i++) put_byte(KW_TEXT[k][8 * i +: 8]);
      end else begin
        put_byte(rand_letter());
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(5, 11)) put_byte(rand_word_char());
        else repeat ($urandom_range(0, 4)) put_byte(rand_word_char());
      end
    end else if (pick < 36) begin
      repeat ($urandom_range(1, 4)) put_byte(rand_digit());
      if ($urandom_range(0, 1) == 1) begin
        put_byte(".");
        repeat ($urandom_range(0, 3)) put_byte(rand_digit());
        if ($urandom_range(0, 7) == 0) put_byte(".");
      end
    end else if (pick < 46) begin
      put_byte(CH_QUOTE);
      repeat ($urandom_range(0, 8)) put_byte(rand_string_char());
      if ($urandom_range(0, 9) != 0) put_byte(CH_QUOTE);
    end else if (pick < 53) begin
      put_text("//");
      repeat ($urandom_range(0, 8)) begin
        b = 8'($urandom_range(0, 255));
        if (b == CH_LF) b = " ";
        put_byte(b);
      end
      put_byte(CH_LF);
    end else if (pick < 76) begin
      put_byte(OP_BYTES[$urandom_range(0, 10)]);
      if ($urandom_range(0, 2) == 0) put_byte("=");
    end else if (pick < 90) begin
      put_byte(WS_BYTES[$urandom_range(0, 3)]);
    end else begin
      b = 8'($urandom_range(0, 255));
      put_byte(b);
    end
  endtask

  task automatic put_random_text();
    repeat ($urandom_range(1, 8)) begin
      put_fragment();
      if ($urandom_range(0, 4) < 2) put_byte(WS_BYTES[$urandom_range(0, 3)]);
    end
    close_text();
  endtask

  task automatic send_item(input logic [8:0] item);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= item[7:0];
    s_axis_tlast <= item[8];
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bytes_sent++;
    if (item[8]) texts_sent++;
  endtask

  task automatic send_queued();
    while (source_q.size() != 0) send_item(source_q.pop_front());
  endtask

  // Hold the source side off until every predicted token has been transferred.
  task automatic drain_tokens();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    put_text("-(1.2.)-or");
    close_text();
    put_text("*/+!==<");
    close_text();
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(CH_QUOTE);
    put_byte("a");
    close_text();
    put_text("//");
    close_text();
    send_queued();
    drain_tokens();

    for (int p = 0; p < 4; p++) begin
      idle_pct = IDLE_PCT[p];
      stall_pct = STALL_PCT[p];
      while (source_q.size() < PHASE_ITEMS) put_random_text();
      send_queued();
      drain_tokens();
    end

    $display("Lexed %0d source bytes in %0d texts under four idle and stall mixes;",
             bytes_sent, texts_sent);
    $display("compared %0d tokens, %0d mismatches.", tokens_checked, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
design/stl_pkg.sv
design/stl_front.sv
design/stl_fifo.sv
design/stl_back.sv
design/script_token_lexer_unit.sv
design/stl_checker.sv
tb/stl_token_checker.sv
tb/tb_script_token_lexer_unit.sv
